### src/tsm_pkg.sv
// Shared types, constants and helpers of the tank steering mixer.
// No dependencies; the front end, queue, write sequencer and top level use it.
package tsm_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int RAW_W   = 8;
  localparam int VAL_W   = 14;
  localparam int LIMIT_W = 7;
  localparam int NSLOT   = 7;

  localparam logic [RAW_W-1:0] RAW_SAT = 8'd200;
  localparam logic [RAW_W-1:0] RAW_CTR = 8'd100;
  localparam logic [VAL_W-1:0] LIMIT_RST_X100 = 14'd3000;
  localparam logic [VAL_W-1:0] PCT_SCALE = 14'd100;

  typedef enum logic [2:0] {
    TGT_EN_LEFT    = 3'd0,
    TGT_EN_RIGHT   = 3'd1,
    TGT_DIR_LEFT   = 3'd2,
    TGT_DIR_RIGHT  = 3'd3,
    TGT_DUTY_LEFT  = 3'd4,
    TGT_DUTY_RIGHT = 3'd5,
    TGT_STOP_ALL   = 3'd6
  } target_t;

  // Slots in emission order; bit n of a job mask is slot n.
  typedef enum logic [2:0] {
    SLOT_STOP   = 3'd0,
    SLOT_EN_L   = 3'd1,
    SLOT_EN_R   = 3'd2,
    SLOT_DIR_L  = 3'd3,
    SLOT_DIR_R  = 3'd4,
    SLOT_DUTY_L = 3'd5,
    SLOT_DUTY_R = 3'd6
  } slot_t;

  typedef struct packed {
    logic [NSLOT-1:0] mask;
    logic             en_val;
    logic             dir_l;
    logic             dir_r;
    logic [VAL_W-1:0] duty_l;
    logic [VAL_W-1:0] duty_r;
  } job_t;

  // Saturate to 200 and recentre to -100..100.
  function automatic logic signed [RAW_W-1:0] centre(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] s;
    s = (raw > RAW_SAT) ? RAW_SAT : raw;
    return signed'(s - RAW_CTR);
  endfunction

  function automatic target_t slot_target(input slot_t s);
    target_t t;
    unique case (s)
      SLOT_STOP:   t = TGT_STOP_ALL;
      SLOT_EN_L:   t = TGT_EN_LEFT;
      SLOT_EN_R:   t = TGT_EN_RIGHT;
      SLOT_DIR_L:  t = TGT_DIR_LEFT;
      SLOT_DIR_R:  t = TGT_DIR_RIGHT;
      SLOT_DUTY_L: t = TGT_DUTY_LEFT;
      SLOT_DUTY_R: t = TGT_DUTY_RIGHT;
      default:     t = TGT_STOP_ALL;
    endcase
    return t;
  endfunction

endpackage

### src/tsm_in_if.sv
// Command request channel of the tank steering mixer.
// Depends on nothing.
interface tsm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] speed_byte;
  logic [7:0] turn_byte;
  modport source (output valid, cmd, speed_byte, turn_byte, input ready);
  modport sink   (input valid, cmd, speed_byte, turn_byte, output ready);
endinterface

### src/tsm_out_if.sv
// Register-write request channel of the tank steering mixer.
// Depends on nothing.
interface tsm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [13:0] write_value;
  logic        last;
  modport source (output valid, target, write_value, last, input ready);
  modport sink   (input valid, target, write_value, last, output ready);
endinterface

### src/tsm_front.sv
// Front end: accepts requests, tracks speed/turn state, mixes wheel values
// and builds write jobs. Depends on tsm_pkg and tsm_in_if.
module tsm_front (
  input  logic                       clk,
  input  logic                       rst_n,
  tsm_in_if.sink                     in_ch,
  input  logic                       cfg_we,
  input  logic [tsm_pkg::LIMIT_W-1:0] cfg_wdata,
  input  logic [tsm_pkg::QCNT_W-1:0] q_count,
  output logic                       push_valid,
  output tsm_pkg::job_t              push_job,
  output logic [1:0]                 inflight
);

  localparam int OCC_W = tsm_pkg::QCNT_W + 1;

  // state
  logic signed [7:0] prev_speed_r, prev_turn_r;
  logic              prev_dl_r, prev_dr_r;
  logic [tsm_pkg::VAL_W-1:0] lim100_r;

  // stage 1
  logic              v1_r, lost1_r, enw1_r, env1_r;
  logic signed [7:0] spd1_r, fl1_r, fr1_r;
  // stage 2
  logic               v2_r, lost2_r, enw2_r, env2_r;
  logic signed [15:0] pl2_r, pr2_r;

  logic              accept;
  logic signed [7:0] speed_c, turn_c, f_c, fl_c, fr_c;
  logic [7:0]        aturn_c;
  logic              changed_c, start_stop_c, v1_nxt;
  logic [OCC_W-1:0]  occ;

  logic [15:0]               negl, negr;
  logic [tsm_pkg::VAL_W-1:0] magl, magr;
  logic                      dl, dr, dirw_l, dirw_r, start2;
  logic [tsm_pkg::NSLOT-1:0] mask;

  assign occ         = OCC_W'(q_count) + OCC_W'(inflight);
  assign in_ch.ready = occ < OCC_W'(tsm_pkg::QDEPTH);
  assign accept      = in_ch.valid && in_ch.ready;

  // Slowed side factor: 100 - 2*|turn|
  always_comb begin
    speed_c      = tsm_pkg::centre(in_ch.speed_byte);
    turn_c       = tsm_pkg::centre(in_ch.turn_byte);
    aturn_c      = turn_c[7] ? 8'(-turn_c) : 8'(turn_c);
    f_c          = signed'(8'd100 - {aturn_c[6:0], 1'b0});
    fl_c         = turn_c[7] ? f_c : 8'sd100;
    fr_c         = (!turn_c[7] && turn_c != 8'sd0) ? f_c : 8'sd100;
    changed_c    = (speed_c != prev_speed_r) || (turn_c != prev_turn_r);
    start_stop_c = (speed_c != 8'sd0) != (prev_speed_r != 8'sd0);
    v1_nxt       = accept && (in_ch.cmd || changed_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_speed_r <= '0;
      prev_turn_r  <= '0;
      lim100_r     <= tsm_pkg::LIMIT_RST_X100;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
    end else begin
      if (cfg_we)
        lim100_r <= tsm_pkg::VAL_W'(cfg_wdata) * tsm_pkg::PCT_SCALE;
      if (accept) begin
        prev_speed_r <= in_ch.cmd ? 8'sd0 : speed_c;
        prev_turn_r  <= in_ch.cmd ? 8'sd0 : turn_c;
      end
      v1_r <= v1_nxt;
      v2_r <= v1_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (v1_nxt) begin
      lost1_r <= in_ch.cmd;
      enw1_r  <= start_stop_c;
      env1_r  <= speed_c != 8'sd0;
      spd1_r  <= speed_c;
      fl1_r   <= fl_c;
      fr1_r   <= fr_c;
    end
    if (v1_r) begin
      lost2_r <= lost1_r;
      enw2_r  <= enw1_r;
      env2_r  <= env1_r;
      pl2_r   <= spd1_r * fl1_r;
      pr2_r   <= spd1_r * fr1_r;
    end
  end

  // Direction bits, magnitudes and the write mask
  always_comb begin
    dl     = !pl2_r[15];
    dr     = !pr2_r[15];
    negl   = 16'(-pl2_r);
    negr   = 16'(-pr2_r);
    magl   = pl2_r[15] ? negl[tsm_pkg::VAL_W-1:0] : pl2_r[tsm_pkg::VAL_W-1:0];
    magr   = pr2_r[15] ? negr[tsm_pkg::VAL_W-1:0] : pr2_r[tsm_pkg::VAL_W-1:0];
    // a start leaves the stored direction unknown, so it always differs
    start2 = enw2_r && env2_r;
    dirw_l = (start2 || dl != prev_dl_r) && (magl < lim100_r);
    dirw_r = (start2 || dr != prev_dr_r) && (magr < lim100_r);
    mask   = '0;
    if (lost2_r) begin
      mask[tsm_pkg::SLOT_STOP] = 1'b1;
      mask[tsm_pkg::SLOT_EN_L] = 1'b1;
      mask[tsm_pkg::SLOT_EN_R] = 1'b1;
    end else begin
      mask[tsm_pkg::SLOT_EN_L]   = enw2_r;
      mask[tsm_pkg::SLOT_EN_R]   = enw2_r;
      mask[tsm_pkg::SLOT_DIR_L]  = dirw_l;
      mask[tsm_pkg::SLOT_DIR_R]  = dirw_r;
      mask[tsm_pkg::SLOT_DUTY_L] = 1'b1;
      mask[tsm_pkg::SLOT_DUTY_R] = 1'b1;
    end
    push_job.mask   = mask;
    push_job.en_val = env2_r && !lost2_r;
    push_job.dir_l  = dl;
    push_job.dir_r  = dr;
    push_job.duty_l = magl;
    push_job.duty_r = magr;
  end

  // Stored directions follow every update, written or not; link loss keeps them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_dl_r <= 1'b0;
      prev_dr_r <= 1'b0;
    end else if (v2_r && !lost2_r) begin
      prev_dl_r <= dl;
      prev_dr_r <= dr;
    end
  end

  assign push_valid = v2_r;
  assign inflight   = {1'b0, v1_r} + {1'b0, v2_r};

endmodule

### src/tsm_queue.sv
// Job queue between front end and write sequencer.
// Depends on tsm_pkg.
module tsm_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  tsm_pkg::job_t              push_job,
  input  logic                       pop,
  output tsm_pkg::job_t              head,
  output logic                       head_valid,
  output logic [tsm_pkg::QCNT_W-1:0] count
);

  tsm_pkg::job_t               mem_r [tsm_pkg::QDEPTH];
  logic [tsm_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [tsm_pkg::QCNT_W-1:0]  cnt_r;
  logic                        do_pop;

  assign do_pop     = pop && cnt_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign head_valid = cnt_r != '0;
  assign count      = cnt_r;

  always_ff @(posedge clk) begin
    if (push)
      mem_r[wr_ptr_r] <= push_job;
  end

  // push only arrives with room; the front end holds a credit for it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == tsm_pkg::QPTR_W'(tsm_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == tsm_pkg::QPTR_W'(tsm_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !do_pop)
        cnt_r <= cnt_r + 1'b1;
      else if (!push && do_pop)
        cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

### src/tsm_back.sv
// Write sequencer: turns queued jobs into register-write requests, one per
// cycle while out_ch is ready, through an output register. Depends on tsm_pkg and tsm_out_if.
module tsm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  tsm_pkg::job_t q_head,
  input  logic          q_valid,
  output logic          q_pop,
  tsm_out_if.source     out_ch
);

  tsm_pkg::job_t             cur_r;
  logic [tsm_pkg::NSLOT-1:0] mask_r, mask_nxt, mask_after, rem;
  logic                      out_valid_r;
  logic [2:0]                target_r;
  logic [tsm_pkg::VAL_W-1:0] value_r, value_c;
  logic                      last_r;
  tsm_pkg::slot_t            sel;
  logic                      has, adv, emit;

  // lowest pending slot goes first
  always_comb begin
    sel = tsm_pkg::SLOT_STOP;
    for (int i = tsm_pkg::NSLOT - 1; i >= 0; i--) begin
      if (mask_r[i])
        sel = tsm_pkg::slot_t'(3'(i));
    end
    has        = |mask_r;
    rem        = mask_r & ~(tsm_pkg::NSLOT'(1) << sel);
    adv        = !out_valid_r || out_ch.ready;
    emit       = adv && has;
    mask_after = emit ? rem : mask_r;
    q_pop      = q_valid && (mask_after == '0);
    mask_nxt   = q_pop ? q_head.mask : mask_after;
  end

  always_comb begin
    unique case (sel)
      tsm_pkg::SLOT_STOP:   value_c = '0;
      tsm_pkg::SLOT_EN_L,
      tsm_pkg::SLOT_EN_R:   value_c = tsm_pkg::VAL_W'(cur_r.en_val);
      tsm_pkg::SLOT_DIR_L:  value_c = tsm_pkg::VAL_W'(cur_r.dir_l);
      tsm_pkg::SLOT_DIR_R:  value_c = tsm_pkg::VAL_W'(cur_r.dir_r);
      tsm_pkg::SLOT_DUTY_L: value_c = cur_r.duty_l;
      tsm_pkg::SLOT_DUTY_R: value_c = cur_r.duty_r;
      default:              value_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (adv)
        out_valid_r <= has;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop)
      cur_r <= q_head;
    if (emit) begin
      target_r <= tsm_pkg::slot_target(sel);
      value_r  <= value_c;
      last_r   <= rem == '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.target      = target_r;
  assign out_ch.write_value = value_r;
  assign out_ch.last        = last_r;

endmodule

### src/tank_steering_motor_mixer.sv
// Top level of the tank steering mixer: front end, job queue and write
// sequencer. Depends on tsm_pkg, tsm_in_if, tsm_out_if and the three units.
//
//  channel  | dir | payload                          | handshake
//  ---------+-----+----------------------------------+---------------------
//  in_ch    | in  | cmd, speed_byte, turn_byte       | valid/ready
//  out_ch   | out | target, write_value, last        | valid/ready
//  cfg_*    | in  | cfg_wdata = dir_change_limit     | cfg_we, no wait
//
//  Each accepted request causes 0 to 6 write requests; the sequencer sends
//  one per cycle while out_ch is ready. Requests are taken every cycle
//  while fewer than 4 jobs sit in the queue and the two mixing stages
//  together; a job passes the two mixing stages, the job queue and the
//  sequencer's mask and output registers before its first write is on out_ch.
//  Reset (rst_n low, synchronous) clears speed, turn, directions, queue and
//  output valid; dir_change_limit returns to 30. No clearing pass.
//  A stalled out_ch holds the sequencer; the front end keeps filling the
//  queue until its credits run out, then drops in_ch.ready.
module tank_steering_motor_mixer (
  input  logic                        clk,
  input  logic                        rst_n,
  tsm_in_if.sink                      in_ch,
  tsm_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [tsm_pkg::LIMIT_W-1:0] cfg_wdata
);

  logic                       push_valid;
  tsm_pkg::job_t              push_job;
  logic [1:0]                 inflight;
  logic [tsm_pkg::QCNT_W-1:0] q_count;
  tsm_pkg::job_t              q_head;
  logic                       q_valid;
  logic                       q_pop;

  // classify, mix and build the write job
  tsm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_count    (q_count),
    .push_valid (push_valid),
    .push_job   (push_job),
    .inflight   (inflight)
  );

  // decouples the mixer from a stalled write port
  tsm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_job   (push_job),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid),
    .count      (q_count)
  );

  // one write request per cycle while out_ch is ready
  tsm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (q_head),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // queue credits never overrun
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (4'(q_count) + 4'(inflight)) <= 4'(tsm_pkg::QDEPTH))
    else $error("job queue credit overrun");

  // a link-lost request always enters the mixing pipeline
  a_lost_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.cmd) |=> (inflight != 2'd0))
    else $error("link-lost request dropped");

  // stop-all always leads a sequence, right duty always ends one
  a_stop_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.target == tsm_pkg::TGT_STOP_ALL) |-> !out_ch.last)
    else $error("stop_all_pwm marked last");

  a_duty_r_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.target == tsm_pkg::TGT_DUTY_RIGHT) |-> out_ch.last)
    else $error("duty_right not marked last");

endmodule
